// ===== src/skc_pkg.sv =====
// Shared types and constants of the solenoid kicker controller.
// Used by skc_ctrl and solenoid_kicker_controller_core; no dependencies.
`timescale 1ns / 1ps

package skc_pkg;

  // Fixed widths of duties, timers, voltages and sequence counters
  localparam int unsigned DUTY_W  = 10;
  localparam int unsigned TIMER_W = 20;
  localparam int unsigned VOLT_W  = 9;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Stream payload widths; the tdata widths are padded to whole bytes
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;

  // Register reset values
  localparam logic [TIMER_W-1:0] KICK_PULSE_RST   = TIMER_W'(10000);
  localparam logic [VOLT_W-1:0]  READY_VOLTS_RST  = VOLT_W'(150);
  localparam logic [DUTY_W-1:0]  MAX_KICK_RST     = DUTY_W'(973);
  localparam logic [DUTY_W-1:0]  DRAIN_DUTY_RST   = DUTY_W'(102);
  localparam logic [TIMER_W-1:0] DRAIN_TOGGLE_RST = TIMER_W'(250000);
  localparam logic [SEQ_W-1:0]   SETTLE_RST       = SEQ_W'(1000);
  localparam logic [SEQ_W-1:0]   LATCH_RESET_RST  = SEQ_W'(200);

  // Command carried in tuser
  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_KICK      = 2'd1,
    CMD_CHARGE    = 2'd2,
    CMD_DISCHARGE = 2'd3
  } cmd_e;

  // Kick kinds that fire a solenoid
  localparam logic [1:0] KIND_STRAIGHT = 2'd1;
  localparam logic [1:0] KIND_CHIP     = 2'd2;

  // Request and mode codes
  typedef enum logic [1:0] {
    REQ_NONE      = 2'd0,
    REQ_CHARGE    = 2'd1,
    REQ_DISCHARGE = 2'd2
  } req_e;

  // Charge start sequence phases
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETTLE = 2'd1,
    PH_LATCH  = 2'd2
  } phase_e;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KICK_PULSE   = 3'd0,
    CFG_READY_VOLTS  = 3'd1,
    CFG_MAX_KICK     = 3'd2,
    CFG_DRAIN_DUTY   = 3'd3,
    CFG_DRAIN_TOGGLE = 3'd4,
    CFG_SETTLE       = 3'd5,
    CFG_LATCH_RESET  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [TIMER_W-1:0] kick_pulse_ticks;
    logic [VOLT_W-1:0]  ready_volts;
    logic [DUTY_W-1:0]  max_kick_duty;
    logic [DUTY_W-1:0]  drain_duty;
    logic [TIMER_W-1:0] drain_toggle_ticks;
    logic [SEQ_W-1:0]   settle_ticks;
    logic [SEQ_W-1:0]   latch_reset_ticks;
  } cfg_t;

  // One input beat, unpacked
  typedef struct packed {
    cmd_e              cmd;
    logic [1:0]        kick_kind;
    logic [DUTY_W-1:0] kick_power;
    logic [VOLT_W-1:0] boost_volts;
  } item_t;

  // One result beat; field order gives the tdata layout (last member lowest)
  typedef struct packed {
    logic              charge_seq_busy;
    logic              drain_active;
    logic              kick_active;
    logic              discharge_pin;
    logic              charge_pin;
    logic [DUTY_W-1:0] chip_duty;
    logic [DUTY_W-1:0] straight_duty;
  } res_t;

endpackage

// ===== src/skc_ctrl.sv =====
// Kicker control state and its one-step update per accepted beat.
// Depends on skc_pkg.
`timescale 1ns / 1ps

module skc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  skc_pkg::item_t item_i,
  input  skc_pkg::cfg_t  cfg_i,
  output skc_pkg::res_t  res_o
);
  import skc_pkg::*;

  logic               kick_on_q, kick_on_d;
  logic               drain_on_q, drain_on_d;
  logic               phase_off_q, phase_off_d;
  logic               charge_q, charge_d;
  logic               discharge_q, discharge_d;
  req_e               pend_q, pend_d;
  req_e               mode_q, mode_d;
  phase_e             phase_q, phase_d;
  logic [TIMER_W-1:0] kick_cnt_q, kick_cnt_d;
  logic [TIMER_W-1:0] drain_cnt_q, drain_cnt_d;
  logic [SEQ_W-1:0]   seq_cnt_q, seq_cnt_d;
  logic [DUTY_W-1:0]  duty1_q, duty1_d;
  logic [DUTY_W-1:0]  duty2_q, duty2_d;

  logic [DUTY_W-1:0]  kick_duty;
  logic [SEQ_W-1:0]   seq_inc;
  req_e               req;

  // Clamp the requested kick duty
  assign kick_duty = (item_i.kick_power > cfg_i.max_kick_duty) ?
                     cfg_i.max_kick_duty : item_i.kick_power;

  // Next state for one beat
  always_comb begin
    kick_on_d   = kick_on_q;
    drain_on_d  = drain_on_q;
    phase_off_d = phase_off_q;
    charge_d    = charge_q;
    discharge_d = discharge_q;
    pend_d      = pend_q;
    mode_d      = mode_q;
    phase_d     = phase_q;
    kick_cnt_d  = kick_cnt_q;
    drain_cnt_d = drain_cnt_q;
    seq_cnt_d   = seq_cnt_q;
    duty1_d     = duty1_q;
    duty2_d     = duty2_q;
    seq_inc     = (&seq_cnt_q) ? seq_cnt_q : seq_cnt_q + SEQ_W'(1);
    req         = REQ_NONE;

    case (item_i.cmd)
      CMD_TICK: begin
        // Advance the kick pulse timer
        if (kick_on_q) begin
          kick_cnt_d = (&kick_cnt_q) ? kick_cnt_q : kick_cnt_q + TIMER_W'(1);
          if (kick_cnt_d >= cfg_i.kick_pulse_ticks) begin
            kick_on_d = 1'b0;
            if (pend_q == REQ_NONE) pend_d = mode_q;
          end
        end
        // Advance the charge start sequence
        unique case (phase_q)
          PH_SETTLE: begin
            if (seq_inc >= cfg_i.settle_ticks) begin
              charge_d  = 1'b0;
              phase_d   = PH_LATCH;
              seq_cnt_d = '0;
            end else begin
              seq_cnt_d = seq_inc;
            end
          end
          PH_LATCH: begin
            if (seq_inc >= cfg_i.latch_reset_ticks) begin
              if (!kick_on_d) charge_d = 1'b1;
              phase_d   = PH_IDLE;
              seq_cnt_d = '0;
            end else begin
              seq_cnt_d = seq_inc;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
        // Advance the drain toggle timer
        if (drain_on_q) begin
          if (((&drain_cnt_q) ? drain_cnt_q : drain_cnt_q + TIMER_W'(1))
              >= cfg_i.drain_toggle_ticks) begin
            phase_off_d = !phase_off_q;
            drain_cnt_d = '0;
          end else begin
            drain_cnt_d = drain_cnt_q + TIMER_W'(1);
          end
        end
        // Take the pending request once no kick runs
        if (!kick_on_d) begin
          req    = pend_d;
          pend_d = REQ_NONE;
          if (req != REQ_NONE) mode_d = req;
          if (req == REQ_CHARGE) begin
            drain_on_d  = 1'b0;
            discharge_d = 1'b0;
            phase_d     = PH_SETTLE;
            seq_cnt_d   = '0;
          end else if (req == REQ_DISCHARGE) begin
            if (!drain_on_d) begin
              drain_cnt_d = '0;
              phase_off_d = 1'b0;
            end
            drain_on_d  = 1'b1;
            charge_d    = 1'b0;
            discharge_d = 1'b1;
            phase_d     = PH_IDLE;
            seq_cnt_d   = '0;
          end
          duty1_d = (drain_on_d && !phase_off_d) ? cfg_i.drain_duty : '0;
          duty2_d = '0;
        end
      end
      CMD_KICK: begin
        // Fire only for a known kind and enough boost voltage
        if ((item_i.kick_kind == KIND_STRAIGHT || item_i.kick_kind == KIND_CHIP) &&
            item_i.boost_volts >= cfg_i.ready_volts) begin
          charge_d    = 1'b0;
          discharge_d = 1'b0;
          drain_on_d  = 1'b0;
          if (item_i.kick_kind == KIND_STRAIGHT) duty1_d = kick_duty;
          else duty2_d = kick_duty;
          kick_cnt_d = '0;
          kick_on_d  = 1'b1;
        end
      end
      CMD_CHARGE:    pend_d = REQ_CHARGE;
      default:       pend_d = REQ_DISCHARGE;
    endcase
  end

  // Hold state between beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kick_on_q   <= 1'b0;
      drain_on_q  <= 1'b0;
      phase_off_q <= 1'b0;
      charge_q    <= 1'b0;
      discharge_q <= 1'b0;
      pend_q      <= REQ_NONE;
      mode_q      <= REQ_NONE;
      phase_q     <= PH_IDLE;
      kick_cnt_q  <= '0;
      drain_cnt_q <= '0;
      seq_cnt_q   <= '0;
      duty1_q     <= '0;
      duty2_q     <= '0;
    end else if (step_i) begin
      kick_on_q   <= kick_on_d;
      drain_on_q  <= drain_on_d;
      phase_off_q <= phase_off_d;
      charge_q    <= charge_d;
      discharge_q <= discharge_d;
      pend_q      <= pend_d;
      mode_q      <= mode_d;
      phase_q     <= phase_d;
      kick_cnt_q  <= kick_cnt_d;
      drain_cnt_q <= drain_cnt_d;
      seq_cnt_q   <= seq_cnt_d;
      duty1_q     <= duty1_d;
      duty2_q     <= duty2_d;
    end
  end

  // Result shows the state after the beat
  always_comb begin
    res_o.straight_duty   = duty1_d;
    res_o.chip_duty       = duty2_d;
    res_o.charge_pin      = charge_d;
    res_o.discharge_pin   = discharge_d;
    res_o.kick_active     = kick_on_d;
    res_o.drain_active    = drain_on_d;
    res_o.charge_seq_busy = (phase_d != PH_IDLE);
  end

  // A running kick keeps both pins low and draining stopped
  a_kick_pins_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kick_on_q |-> (!charge_q && !discharge_q && !drain_on_q))
    else $error("pins or drain active during kick");

  // Draining and the charge sequence never run together
  a_drain_no_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_on_q |-> (phase_q == PH_IDLE))
    else $error("charge sequence running while draining");

  // Draining always drives the discharge pin
  a_drain_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_on_q |-> discharge_q)
    else $error("drain active with discharge pin low");

  // A tick with no kick running leaves no pending request
  a_req_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.cmd == CMD_TICK && !kick_on_d) |=> (pend_q == REQ_NONE))
    else $error("request left pending after tick");

endmodule

// ===== src/solenoid_kicker_controller_core.sv =====
// Top level of the solenoid kicker controller: stream ports, register file
// and result register. Depends on skc_pkg and skc_ctrl.
`timescale 1ns / 1ps

// Each input beat (a tick, a kick or a charge/discharge request, selected by
// tuser) produces exactly one output beat holding the duties, pin levels and
// status flags as they stand after that beat. The state update is a single
// pass of compares and counter increments from the state registers into the
// result register, so a new beat is accepted every cycle as long as the
// output side takes results. Configuration writes are accepted in any cycle
// and should be made only while the block is idle.
module solenoid_kicker_controller_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] kick_kind, [11:2] kick_power, [20:12] boost_volts, rest zero
  input  logic [skc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [skc_pkg::IN_USER_W-1:0] s_axis_tuser,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [9:0] straight_duty, [19:10] chip_duty, [20] charge_pin,
  // [21] discharge_pin, [22] kick_active, [23] drain_active,
  // [24] charge_seq_busy, rest zero
  output logic [skc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Register write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [skc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [skc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import skc_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  res_t  res_d, res_q;
  logic  out_valid_q;
  logic  in_fire;

  // Unpack the input beat
  assign item.cmd         = cmd_e'(s_axis_tuser);
  assign item.kick_kind   = s_axis_tdata[1:0];
  assign item.kick_power  = s_axis_tdata[11:2];
  assign item.boost_volts = s_axis_tdata[20:12];

  // Accept while the result register is empty or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Register file
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kick_pulse_ticks   <= KICK_PULSE_RST;
      cfg_q.ready_volts        <= READY_VOLTS_RST;
      cfg_q.max_kick_duty      <= MAX_KICK_RST;
      cfg_q.drain_duty         <= DRAIN_DUTY_RST;
      cfg_q.drain_toggle_ticks <= DRAIN_TOGGLE_RST;
      cfg_q.settle_ticks       <= SETTLE_RST;
      cfg_q.latch_reset_ticks  <= LATCH_RESET_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KICK_PULSE:   cfg_q.kick_pulse_ticks   <= cfg_data_i[TIMER_W-1:0];
        CFG_READY_VOLTS:  cfg_q.ready_volts        <= cfg_data_i[VOLT_W-1:0];
        CFG_MAX_KICK:     cfg_q.max_kick_duty      <= cfg_data_i[DUTY_W-1:0];
        CFG_DRAIN_DUTY:   cfg_q.drain_duty         <= cfg_data_i[DUTY_W-1:0];
        CFG_DRAIN_TOGGLE: cfg_q.drain_toggle_ticks <= cfg_data_i[TIMER_W-1:0];
        CFG_SETTLE:       cfg_q.settle_ticks       <= cfg_data_i[SEQ_W-1:0];
        CFG_LATCH_RESET:  cfg_q.latch_reset_ticks  <= cfg_data_i[SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state and its update
  skc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .item_i (item),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // Result register: load on accept, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, res_q};

  // Every accepted beat leaves a result waiting in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  // A stalled result keeps its payload when no new beat enters
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(res_q))
    else $error("stalled result overwritten");

endmodule
